// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_CROSSING,
		MODE_START
	} mode_t;

	typedef enum logic [1:0] {
		CMP_A,
		CMP_B,
		CMP_C
	} cmp_t;

	typedef enum logic [1:0] {
		REG_START_PHASE,
		REG_START_PERIOD,
		REG_TIMING_ADVANCE
	} reg_idx_t;

	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned MEAS_W   = 16;
	localparam int unsigned ERR_W    = 17;
	localparam int unsigned CORR_W   = 10;

	localparam logic [2:0]  RST_START_PHASE  = 3'd0;
	localparam logic [15:0] RST_START_PERIOD = 16'd1000;
	localparam logic [4:0]  RST_ADVANCE      = 5'd5;
	localparam logic [4:0]  MAX_ADVANCE      = 5'd30;
	localparam logic [15:0] MEAS_MAX         = 16'hFFFF;

	// target = (period * TGT_MULT[adv]) >> TGT_SHIFT == floor(period * (30 - adv) / 60)
	localparam int unsigned TGT_SHIFT = 22;
	localparam int unsigned TGT_W     = 22;
	localparam logic [TGT_W-1:0] TGT_MULT [0:30] = '{
		22'(((30 - 0) * 4194304) / 60 + 1),
		22'(((30 - 1) * 4194304) / 60 + 1),
		22'(((30 - 2) * 4194304) / 60 + 1),
		22'(((30 - 3) * 4194304) / 60 + 1),
		22'(((30 - 4) * 4194304) / 60 + 1),
		22'(((30 - 5) * 4194304) / 60 + 1),
		22'(((30 - 6) * 4194304) / 60 + 1),
		22'(((30 - 7) * 4194304) / 60 + 1),
		22'(((30 - 8) * 4194304) / 60 + 1),
		22'(((30 - 9) * 4194304) / 60 + 1),
		22'(((30 - 10) * 4194304) / 60 + 1),
		22'(((30 - 11) * 4194304) / 60 + 1),
		22'(((30 - 12) * 4194304) / 60 + 1),
		22'(((30 - 13) * 4194304) / 60 + 1),
		22'(((30 - 14) * 4194304) / 60 + 1),
		22'(((30 - 15) * 4194304) / 60 + 1),
		22'(((30 - 16) * 4194304) / 60 + 1),
		22'(((30 - 17) * 4194304) / 60 + 1),
		22'(((30 - 18) * 4194304) / 60 + 1),
		22'(((30 - 19) * 4194304) / 60 + 1),
		22'(((30 - 20) * 4194304) / 60 + 1),
		22'(((30 - 21) * 4194304) / 60 + 1),
		22'(((30 - 22) * 4194304) / 60 + 1),
		22'(((30 - 23) * 4194304) / 60 + 1),
		22'(((30 - 24) * 4194304) / 60 + 1),
		22'(((30 - 25) * 4194304) / 60 + 1),
		22'(((30 - 26) * 4194304) / 60 + 1),
		22'(((30 - 27) * 4194304) / 60 + 1),
		22'(((30 - 28) * 4194304) / 60 + 1),
		22'(((30 - 29) * 4194304) / 60 + 1),
		22'(((30 - 30) * 4194304) / 60 + 1)
	};

	// |err| / 200 == ((|err| >> 3) * CORR_MULT) >> CORR_SHIFT for |err| < 2^16
	localparam int unsigned CORR_PRESHIFT = 3;
	localparam logic [13:0] CORR_MULT     = 14'd10486;
	localparam int unsigned CORR_SHIFT    = 18;

	typedef struct packed {
		logic [2:0]  start_phase;
		logic [15:0] start_period;
		logic [4:0]  advance;
	} cfg_t;

	typedef struct packed {
		logic [2:0]               phase;
		logic [2:0]               enables;
		logic                     commutated;
		logic [PERIOD_W-1:0]      period;
		logic                     taken;
		logic [MEAS_W-1:0]        meas;
		logic signed [ERR_W-1:0]  err;
	} res_t;

	function automatic logic [2:0] next_phase(input logic [2:0] p);
		logic [2:0] n;
		case (p)
			3'd0: n = 3'd1;
			3'd1: n = 3'd2;
			3'd2: n = 3'd3;
			3'd3: n = 3'd4;
			3'd4: n = 3'd5;
			3'd5: n = 3'd0;
			3'd6: n = 3'd1;
			3'd7: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// comparator that each phase watches: bit0 A, bit1 B, bit2 C
	function automatic logic [2:0] watch_mask(input logic [2:0] p);
		logic [2:0] m;
		case (p)
			3'd0, 3'd3: m = 3'b010;
			3'd1, 3'd4: m = 3'b001;
			3'd2, 3'd5: m = 3'b100;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/bsc_corr.sv =====
module bsc_corr (
	input  logic signed [bsc_pkg::ERR_W-1:0]  err,
	input  logic [bsc_pkg::PERIOD_W-1:0]      period_in,
	output logic signed [bsc_pkg::CORR_W-1:0] corr,
	output logic [bsc_pkg::PERIOD_W-1:0]      period_out
);

	logic [bsc_pkg::ERR_W-1:0] mag_full;
	logic [15:0]               mag;
	logic [12:0]               mag_div8;
	logic [26:0]               prod;
	logic [8:0]                quot;
	logic signed [17:0]        next;

	always_comb begin
		mag_full = err[bsc_pkg::ERR_W-1] ? (bsc_pkg::ERR_W'(0) - err) : err;
		mag      = mag_full[15:0];
		mag_div8 = mag[15:bsc_pkg::CORR_PRESHIFT];
		prod     = 27'(mag_div8) * 27'(bsc_pkg::CORR_MULT);
		quot     = prod[26:bsc_pkg::CORR_SHIFT];
		corr     = err[bsc_pkg::ERR_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		next     = $signed({2'b00, period_in}) - 18'(corr);
		// keep the period in 1..65535
		if (next < 18'sd1) begin
			period_out = 16'd1;
		end else if (next > 18'sd65535) begin
			period_out = 16'hFFFF;
		end else begin
			period_out = next[15:0];
		end
	end

endmodule

// ===== hdl/bsc_ctrl.sv =====
module bsc_ctrl #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          mode,
	input  logic [1:0]          comparator,
	input  bsc_pkg::cfg_t       cfg,
	output bsc_pkg::res_t       res
);

	logic [2:0]                        phase_q;
	logic [bsc_pkg::PERIOD_W-1:0]      period_q;
	logic signed [bsc_pkg::ERR_W-1:0]  err_q;
	logic [bsc_pkg::PERIOD_W-1:0]      countdown_q;
	logic                              running_q;
	logic                              measuring_q;
	logic [TIME_BITS-1:0]              elapsed_q;
	logic [2:0]                        enables_q;

	logic [2:0]                        phase_n;
	logic [bsc_pkg::PERIOD_W-1:0]      period_n;
	logic signed [bsc_pkg::ERR_W-1:0]  err_n;
	logic [bsc_pkg::PERIOD_W-1:0]      countdown_n;
	logic                              running_n;
	logic                              measuring_n;
	logic [TIME_BITS-1:0]              elapsed_n;
	logic [2:0]                        enables_n;

	logic [bsc_pkg::PERIOD_W-1:0]      period_eff;
	logic signed [bsc_pkg::CORR_W-1:0] corr_pending;
	logic [bsc_pkg::PERIOD_W-1:0]      start_period;
	logic [4:0]                        adv_sat;
	logic [37:0]                       tgt_prod;
	logic [15:0]                       target;
	logic [bsc_pkg::MEAS_W-1:0]        meas;
	logic                              cmp_hit;
	logic                              commutated;
	logic                              taken;

	// the correction of a crossing is registered in err_q and then applied to period_q
	bsc_corr u_corr (
		.err        (err_q),
		.period_in  (period_q),
		.corr       (corr_pending),
		.period_out (period_eff)
	);

	always_comb begin
		case (comparator)
			bsc_pkg::CMP_A: cmp_hit = enables_q[0];
			bsc_pkg::CMP_B: cmp_hit = enables_q[1];
			bsc_pkg::CMP_C: cmp_hit = enables_q[2];
			default:        cmp_hit = 1'b0;
		endcase
	end

	// a crossing never follows a crossing directly, so err_q is zero here
	always_comb begin
		adv_sat  = (cfg.advance > bsc_pkg::MAX_ADVANCE) ? bsc_pkg::MAX_ADVANCE : cfg.advance;
		tgt_prod = 38'(period_q) * 38'(bsc_pkg::TGT_MULT[adv_sat]);
		target   = tgt_prod[37:bsc_pkg::TGT_SHIFT];
		meas     = (32'(elapsed_q) > 32'(bsc_pkg::MEAS_MAX)) ? bsc_pkg::MEAS_MAX
			: 16'(elapsed_q);
		start_period = (cfg.start_period == '0) ? 16'd1 : cfg.start_period;
	end

	always_comb begin
		phase_n     = phase_q;
		period_n    = period_eff;
		err_n       = '0;
		countdown_n = countdown_q;
		running_n   = running_q;
		measuring_n = measuring_q;
		elapsed_n   = elapsed_q;
		enables_n   = enables_q;
		commutated  = 1'b0;
		taken       = 1'b0;
		res.meas    = '0;
		res.err     = '0;
		if (accept) begin
			case (mode)
				bsc_pkg::MODE_START: begin
					period_n    = start_period;
					running_n   = 1'b1;
					phase_n     = bsc_pkg::next_phase(cfg.start_phase);
					enables_n   = bsc_pkg::watch_mask(phase_n);
					measuring_n = 1'b1;
					elapsed_n   = '0;
					countdown_n = start_period;
					commutated  = 1'b1;
				end
				bsc_pkg::MODE_TICK: begin
					if (running_q) begin
						if (measuring_q && (elapsed_q != {TIME_BITS{1'b1}})) begin
							elapsed_n = elapsed_q + TIME_BITS'(1);
						end
						if (countdown_q <= 16'd1) begin
							phase_n     = bsc_pkg::next_phase(phase_q);
							enables_n   = bsc_pkg::watch_mask(phase_n);
							measuring_n = 1'b1;
							elapsed_n   = '0;
							countdown_n = period_eff;
							commutated  = 1'b1;
						end else begin
							countdown_n = countdown_q - 16'd1;
						end
					end
				end
				bsc_pkg::MODE_CROSSING: begin
					if (measuring_q && cmp_hit) begin
						measuring_n = 1'b0;
						enables_n   = '0;
						err_n       = $signed({1'b0, target}) - $signed({1'b0, meas});
						taken       = 1'b1;
						res.meas    = meas;
						res.err     = err_n;
					end
				end
				default: begin
				end
			endcase
		end
		res.phase      = phase_n;
		res.enables    = enables_n;
		res.commutated = commutated;
		res.period     = period_n;
		res.taken      = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			period_q    <= bsc_pkg::RST_START_PERIOD;
			err_q       <= '0;
			countdown_q <= '0;
			running_q   <= 1'b0;
			measuring_q <= 1'b0;
			elapsed_q   <= '0;
			enables_q   <= '0;
		end else begin
			phase_q     <= phase_n;
			period_q    <= period_n;
			err_q       <= err_n;
			countdown_q <= countdown_n;
			running_q   <= running_n;
			measuring_q <= measuring_n;
			elapsed_q   <= elapsed_n;
			enables_q   <= enables_n;
		end
	end

endmodule

// ===== hdl/bsc_out.sv =====
module bsc_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  bsc_pkg::res_t                     res,
	output logic                              ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        phase_state,
	output logic [2:0]                        comparator_enables,
	output logic                              commutated,
	output logic [bsc_pkg::PERIOD_W-1:0]      period,
	output logic                              crossing_taken,
	output logic [bsc_pkg::MEAS_W-1:0]        measured_time,
	output logic signed [bsc_pkg::ERR_W-1:0]  timing_error,
	output logic signed [bsc_pkg::CORR_W-1:0] correction
);

	logic                              valid_s1;
	bsc_pkg::res_t                     res_s1;
	logic                              valid_s2;
	logic signed [bsc_pkg::CORR_W-1:0] corr_c;
	logic [bsc_pkg::PERIOD_W-1:0]      period_c;
	logic                              adv_s2;

	// error is zero for items without a crossing, leaving the period as is
	bsc_corr u_corr (
		.err        (res_s1.err),
		.period_in  (res_s1.period),
		.corr       (corr_c),
		.period_out (period_c)
	);

	assign adv_s2    = !valid_s2 || out_ready;
	assign ready     = !valid_s1 || adv_s2;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready) begin
				valid_s1 <= push;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && ready) begin
			res_s1 <= res;
		end
		if (adv_s2 && valid_s1) begin
			phase_state        <= res_s1.phase;
			comparator_enables <= res_s1.enables;
			commutated         <= res_s1.commutated;
			period             <= period_c;
			crossing_taken     <= res_s1.taken;
			measured_time      <= res_s1.meas;
			timing_error       <= res_s1.err;
			correction         <= corr_c;
		end
	end

endmodule

// ===== hdl/bldc_sensorless_commutation_top.sv =====
// six-step sensorless commutator, one item in, one result item out
// an item's result passes the res_s1 and then the output registers before it can be taken
// throughput: one item per cycle while out_ready holds; a crossing's correction passes err_q
// on its way to the period register and is applied to the reported period in stage two
// reset: phase 0, period 1000, not running, all comparators disabled,
// registers start_phase 0, start_period 1000, timing_advance 5
module bldc_sensorless_commutation_top #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [1:0]                        comparator,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        phase_state,
	output logic [2:0]                        comparator_enables,
	output logic                              commutated,
	output logic [bsc_pkg::PERIOD_W-1:0]      period,
	output logic                              crossing_taken,
	output logic [bsc_pkg::MEAS_W-1:0]        measured_time,
	output logic signed [bsc_pkg::ERR_W-1:0]  timing_error,
	output logic signed [bsc_pkg::CORR_W-1:0] correction,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_addr,
	input  logic [15:0]                       cfg_wdata
);

	bsc_pkg::cfg_t cfg_q;
	bsc_pkg::res_t res;
	logic          accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_phase  <= bsc_pkg::RST_START_PHASE;
			cfg_q.start_period <= bsc_pkg::RST_START_PERIOD;
			cfg_q.advance      <= bsc_pkg::RST_ADVANCE;
		end else if (cfg_we) begin
			case (cfg_addr)
				bsc_pkg::REG_START_PHASE:    cfg_q.start_phase  <= cfg_wdata[2:0];
				bsc_pkg::REG_START_PERIOD:   cfg_q.start_period <= cfg_wdata;
				bsc_pkg::REG_TIMING_ADVANCE: cfg_q.advance      <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	bsc_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.comparator (comparator),
		.cfg        (cfg_q),
		.res        (res)
	);

	bsc_out u_out (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (accept),
		.res                (res),
		.ready              (in_ready),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.phase_state        (phase_state),
		.comparator_enables (comparator_enables),
		.commutated         (commutated),
		.period             (period),
		.crossing_taken     (crossing_taken),
		.measured_time      (measured_time),
		.timing_error       (timing_error),
		.correction         (correction)
	);

endmodule
